@@ hw/rtl/tbdf_pkg.sv @@
// Package for the texture border dilation fill block: types, constants and helpers.
`timescale 1ns / 1ps
package tbdf_pkg;

  localparam int unsigned MaxSide = 256;
  localparam int unsigned SideW = 9;
  localparam int unsigned PassW = 8;
  localparam int unsigned IdxW = 16;
  localparam int unsigned ColorW = 24;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgAddrW-1:0] RegSideLength = 1'd0;
  localparam logic [CfgAddrW-1:0] RegPassCount = 1'd1;

  localparam logic [2:0] DirW = 3'd0;
  localparam logic [2:0] DirNW = 3'd1;
  localparam logic [2:0] DirN = 3'd2;
  localparam logic [2:0] DirNE = 3'd3;
  localparam logic [2:0] DirE = 3'd4;
  localparam logic [2:0] DirSE = 3'd5;
  localparam logic [2:0] DirS = 3'd6;
  localparam logic [2:0] DirSW = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS_START,
    ST_CENTER,
    ST_NEIGH,
    ST_DECIDE,
    ST_FETCH,
    ST_WRITE,
    ST_NEXT,
    ST_CLEAR,
    ST_PASS_END
  } tbdf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic pass_init;
    logic rd_center;
    logic rd_neigh;
    logic neigh_cap;
    logic rd_pick;
    logic wr_fill;
    logic step_pixel;
    logic clear_init;
    logic clear_step;
    logic pass_done;
    logic round_done;
  } tbdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic center_cov;
    logic neigh_last;
    logic any_cov;
    logic pixel_last;
    logic clear_last;
    logic passes_left;
  } tbdf_sts_t;

  function automatic logic signed [2:0] dir_dx(input logic [2:0] d);
    logic signed [2:0] r;
    unique case (d)
      DirW, DirNW, DirSW: r = -3'sd1;
      DirN, DirS: r = 3'sd0;
      default: r = 3'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] dir_dy(input logic [2:0] d);
    logic signed [2:0] r;
    unique case (d)
      DirNW, DirN, DirNE: r = -3'sd1;
      DirW, DirE: r = 3'sd0;
      default: r = 3'sd1;
    endcase
    return r;
  endfunction

  // Exact angular sector of the offset sum.
  function automatic logic [2:0] sector_of(input logic signed [4:0] sx,
                                           input logic signed [4:0] sy);
    logic [2:0] r;
    if (sx == 5'sd0 && sy == 5'sd0) r = DirE;
    else if (sy < 5'sd0) begin
      if (sx < 5'sd0) r = (sy > sx) ? DirW : DirNW;
      else if (sx < -sy) r = DirN;
      else r = DirNE;
    end else if (sy == 5'sd0) r = (sx > 5'sd0) ? DirE : DirW;
    else if (sx > 5'sd0) r = (sy < sx) ? DirE : DirSE;
    else if (sy > -sx) r = DirS;
    else r = DirSW;
    return r;
  endfunction

endpackage

@@ hw/rtl/tbdf_ctrl.sv @@
// Controller state machine for loading, reading and the dilation passes.
`timescale 1ns / 1ps
module tbdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               kind_i,
  input  logic               last_i,
  input  tbdf_pkg::tbdf_sts_t sts_i,
  output tbdf_pkg::tbdf_cmd_t cmd_o,
  output logic               busy_o
);
  import tbdf_pkg::*;

  tbdf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i) begin
            cmd_o.read = 1'b1;
            state_d = ST_READ;
          end else begin
            cmd_o.load = 1'b1;
            if (last_i) state_d = ST_PASS_START;
          end
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_PASS_START: begin
        if (sts_i.passes_left) begin
          cmd_o.pass_init = 1'b1;
          state_d = ST_CENTER;
        end else begin
          cmd_o.round_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CENTER: begin
        cmd_o.rd_center = 1'b1;
        state_d = ST_NEIGH;
      end
      ST_NEIGH: begin
        // The center cover bit read in ST_CENTER shows here.
        if (sts_i.center_cov) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.rd_neigh = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.neigh_cap = 1'b1;
        if (sts_i.neigh_last) state_d = ST_FETCH;
        else cmd_o.rd_neigh = 1'b1;
      end
      ST_FETCH: begin
        if (sts_i.any_cov) begin
          cmd_o.rd_pick = 1'b1;
          state_d = ST_WRITE;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_fill = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.step_pixel = 1'b1;
        if (sts_i.pixel_last) begin
          cmd_o.clear_init = 1'b1;
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_CENTER;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = ST_PASS_END;
      end
      ST_PASS_END: begin
        cmd_o.pass_done = 1'b1;
        state_d = ST_PASS_START;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/tbdf_datapath.sv @@
// Datapath: pixel memories, scan counters, neighbor gathering and read-back.
`timescale 1ns / 1ps
module tbdf_datapath #(
  parameter int unsigned MAX_SIDE = tbdf_pkg::MaxSide
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbdf_pkg::tbdf_cmd_t         cmd_i,
  output tbdf_pkg::tbdf_sts_t         sts_o,
  input  logic                        cfg_we_i,
  input  logic [tbdf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tbdf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic                        covered_i,
  input  logic [tbdf_pkg::IdxW-1:0]   read_index_i,
  output logic                        done_o,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_blue_o,
  output logic                        out_covered_o,
  output logic [tbdf_pkg::IdxW-1:0]   out_index_o
);
  import tbdf_pkg::*;

  localparam int unsigned Cells = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned CW = $clog2(MAX_SIDE + 1);
  localparam int unsigned TW = $clog2(Cells + 1);

  logic [ColorW-1:0] color_mem [Cells];
  logic [1:0]        cover_mem [Cells];

  logic [SideW-1:0] side_q;
  logic [PassW-1:0] pass_count_q, passes_done_q;
  logic [IdxW-1:0]  load_pos_q;

  // Effective side, clamped to one through MAX_SIDE.
  logic [CW-1:0] side;
  logic [TW-1:0] total;
  always_comb begin
    if (side_q == '0) side = CW'(1);
    else if (32'(side_q) > MAX_SIDE) side = CW'(MAX_SIDE);
    else side = CW'(side_q);
  end
  assign total = TW'(side) * TW'(side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(256);
      pass_count_q <= PassW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegSideLength: side_q <= cfg_wdata_i[SideW-1:0];
        RegPassCount: pass_count_q <= cfg_wdata_i[PassW-1:0];
        default: ;
      endcase
    end
  end

  // Scan position and neighbor walk.
  logic [CW-1:0] x_q, y_q;
  logic [AW-1:0] idx_q, clr_q;
  logic [2:0]    dir_q, cap_dir_q, last_dir_q;
  logic          cap_ok_q, any_q;
  logic [7:0]    ok_q;
  logic signed [4:0] sx_q, sy_q;

  logic signed [CW+1:0] nx, ny;
  logic          n_in;
  logic [AW-1:0] n_addr;
  assign nx = $signed({2'b00, x_q}) + (CW+2)'(dir_dx(dir_q));
  assign ny = $signed({2'b00, y_q}) + (CW+2)'(dir_dy(dir_q));
  assign n_in = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b00, side}))
              && (ny < $signed({2'b00, side}));
  assign n_addr = AW'(ny[CW-1:0] * side) + AW'(nx[CW-1:0]);

  logic [2:0] sect, pick_dir;
  assign sect = sector_of(sx_q, sy_q);
  assign pick_dir = ok_q[sect] ? sect : last_dir_q;

  logic signed [CW+1:0] px, py;
  logic [AW-1:0] p_addr;
  assign px = $signed({2'b00, x_q}) + (CW+2)'(dir_dx(pick_dir));
  assign py = $signed({2'b00, y_q}) + (CW+2)'(dir_dy(pick_dir));
  assign p_addr = AW'(py[CW-1:0] * side) + AW'(px[CW-1:0]);

  logic [ColorW-1:0] color_rd_q;
  logic [1:0]        cover_rd_q;
  logic              rd_in_q;
  logic [IdxW-1:0]   rd_idx_q;

  // The center cover word is kept for the fill write.
  logic [1:0]    cover_mem_hold_q;
  logic          clr_wr_q;
  logic [AW-1:0] clr_wa_q;
  logic          center_q;

  // Memory address selection.
  logic [AW-1:0] raddr;
  always_comb begin
    raddr = idx_q;
    if (cmd_i.read) raddr = AW'(read_index_i);
    else if (cmd_i.rd_neigh) raddr = n_addr;
    else if (cmd_i.rd_pick) raddr = p_addr;
    else if (cmd_i.clear_step) raddr = clr_q;
  end

  always_ff @(posedge clk_i) begin
    color_rd_q <= color_mem[raddr];
    cover_rd_q <= cover_mem[raddr];
    if (cmd_i.load && (TW'(load_pos_q) < total)) begin
      color_mem[AW'(load_pos_q)] <= {red_i, green_i, blue_i};
      cover_mem[AW'(load_pos_q)] <= {1'b0, covered_i};
    end else if (cmd_i.wr_fill) begin
      color_mem[idx_q] <= color_rd_q;
      cover_mem[idx_q] <= {1'b1, cover_mem_hold_q[0]};
    end else if (clr_wr_q) begin
      if (cover_rd_q[1]) cover_mem[clr_wa_q] <= 2'b01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      passes_done_q <= '0;
      x_q <= '0;
      y_q <= '0;
      idx_q <= '0;
      clr_q <= '0;
      dir_q <= '0;
      cap_dir_q <= '0;
      cap_ok_q <= 1'b0;
      last_dir_q <= '0;
      any_q <= 1'b0;
      ok_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
      rd_in_q <= 1'b0;
      rd_idx_q <= '0;
      done_o <= 1'b0;
      cover_mem_hold_q <= '0;
      clr_wr_q <= 1'b0;
      clr_wa_q <= '0;
      center_q <= 1'b0;
    end else begin
      done_o <= cmd_i.read;
      center_q <= cmd_i.rd_center;
      clr_wr_q <= cmd_i.clear_step;
      clr_wa_q <= clr_q;
      if (center_q) cover_mem_hold_q <= cover_rd_q;
      if (cmd_i.read) begin
        rd_in_q <= (32'(read_index_i) < 32'(total));
        rd_idx_q <= read_index_i;
      end
      if (cmd_i.load) load_pos_q <= load_pos_q + 1'b1;
      if (cmd_i.round_done) load_pos_q <= '0;
      if (cmd_i.pass_init && passes_done_q == pass_count_q) begin
        passes_done_q <= passes_done_q;
      end
      if (cmd_i.load && !cmd_i.pass_init) begin
        passes_done_q <= '0;
      end
      if (cmd_i.pass_done) passes_done_q <= passes_done_q + 1'b1;
      if (cmd_i.pass_init) begin
        x_q <= '0;
        y_q <= '0;
        idx_q <= '0;
      end
      if (cmd_i.rd_center) begin
        dir_q <= '0;
        sx_q <= '0;
        sy_q <= '0;
        ok_q <= '0;
        any_q <= 1'b0;
        cap_ok_q <= 1'b0;
      end
      if (cmd_i.rd_neigh) begin
        cap_dir_q <= dir_q;
        cap_ok_q <= n_in;
        dir_q <= dir_q + 1'b1;
      end
      if (cmd_i.neigh_cap && cap_ok_q && cover_rd_q[0]) begin
        ok_q[cap_dir_q] <= 1'b1;
        any_q <= 1'b1;
        last_dir_q <= cap_dir_q;
        sx_q <= sx_q + 5'(dir_dx(cap_dir_q));
        sy_q <= sy_q + 5'(dir_dy(cap_dir_q));
      end
      if (cmd_i.step_pixel) begin
        idx_q <= idx_q + 1'b1;
        if (x_q == side - 1'b1) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (cmd_i.clear_init) clr_q <= '0;
      else if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.center_cov = cover_rd_q[0];
  assign sts_o.neigh_last = (cap_dir_q == DirSW);
  assign sts_o.any_cov = any_q;
  assign sts_o.pixel_last = (TW'(idx_q) == total - 1'b1);
  assign sts_o.clear_last = (TW'(clr_q) == total - 1'b1);
  assign sts_o.passes_left = (passes_done_q != pass_count_q);

  assign out_red_o = rd_in_q ? color_rd_q[23:16] : 8'd0;
  assign out_green_o = rd_in_q ? color_rd_q[15:8] : 8'd0;
  assign out_blue_o = rd_in_q ? color_rd_q[7:0] : 8'd0;
  assign out_covered_o = rd_in_q ? cover_rd_q[0] : 1'b0;
  assign out_index_o = rd_idx_q;

endmodule

@@ hw/rtl/texture_border_dilation_fill.sv @@
// Top level of the texture border dilation fill block.
//
// Channel  Direction  Signals
// cmd      in         start_i, busy_o, kind_i, red_i, green_i, blue_i, covered_i,
//                     last_i, read_index_i
// result   out        done_o, out_red_o, out_green_o, out_blue_o, out_covered_o,
//                     out_index_o
// cfg      in         cfg_we_i, cfg_addr_i, cfg_wdata_i
//
// A load writes one pixel; a registered read shows done_o for one cycle.
// A load marked last runs pass_count passes; each pass visits every pixel, reading
// its cover bit and, for an open one, its eight neighbors one at a time, bound by
// the single memory read port, then the color of a picked covered neighbor to fill
// it; then it sweeps the frame once more to settle fill marks, so busy_o stays high
// for the whole run.
// Reset sets control and config regs; pixel memories hold anything until loaded.
// The receiver cannot stall results.
`timescale 1ns / 1ps
module texture_border_dilation_fill #(
  parameter int unsigned MAX_SIDE = tbdf_pkg::MaxSide
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          covered_i,
  input  logic                          last_i,
  input  logic [tbdf_pkg::IdxW-1:0]     read_index_i,
  output logic                          done_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic                          out_covered_o,
  output logic [tbdf_pkg::IdxW-1:0]     out_index_o,
  input  logic                          cfg_we_i,
  input  logic [tbdf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tbdf_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tbdf_pkg::*;

  tbdf_cmd_t cmd;
  tbdf_sts_t sts;

  tbdf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i, .last_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  tbdf_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .red_i, .green_i, .blue_i, .covered_i, .read_index_i,
    .done_o, .out_red_o, .out_green_o, .out_blue_o, .out_covered_o, .out_index_o
  );

endmodule
